>>> src/ptrt_pkg.sv
// shared types and constants for the periodic task release timer
// item and result structs, command codes, default sizes; no dependencies
package ptrt_pkg;

  localparam int TASK_SLOTS_DEF = 8;
  localparam int COUNT_BITS_DEF = 16;
  localparam int MAX_SLOTS      = 8;
  localparam int IDX_BITS       = 3;
  localparam int TICK_BITS      = 16;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_SUSPEND = 2'd2,
    CMD_SLEEP   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [IDX_BITS-1:0]   task_index;
    logic [TICK_BITS-1:0]  period_ticks;
    logic [TICK_BITS-1:0]  delay_ticks;
  } item_t;

  typedef struct packed {
    logic [MAX_SLOTS-1:0] due_mask;
    logic                 running;
  } result_t;

  // per-slot strobes decoded from one item
  typedef struct packed {
    logic tick;
    logic load;
    logic suspend;
  } slot_ctl_t;

endpackage

>>> src/ptrt_slot.sv
// one task slot: countdown, reload period and active bit
// depends on ptrt_pkg for the slot control struct and the default count width
module ptrt_slot #(
  parameter int COUNT_BITS = ptrt_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ptrt_pkg::slot_ctl_t   ctl,
  input  logic [COUNT_BITS-1:0] period,
  input  logic [COUNT_BITS-1:0] delay,
  output logic                  due
);

  logic [COUNT_BITS-1:0] countdown;
  logic [COUNT_BITS-1:0] reload_period;
  logic                  active;
  logic [COUNT_BITS-1:0] base;

  assign due  = ctl.tick && active && (countdown == '0);
  // a released slot reloads first, then takes the same decrement
  assign base = due ? reload_period : countdown;

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown     <= '0;
      reload_period <= '0;
      active        <= 1'b0;
    end else if (ctl.load) begin
      countdown     <= delay;
      reload_period <= period;
      active        <= 1'b1;
    end else if (ctl.suspend) begin
      active <= 1'b0;
    end else if (ctl.tick) begin
      countdown <= base - COUNT_BITS'(1);
    end
  end

endmodule

>>> src/periodic_task_release_timer_core.sv
// periodic task release timer: input register, slot bank, result register
// an item is held in the input register, then its result is registered when it advances
// throughput: one item per cycle unless the output stalls; all slots update in parallel on a tick
// the output handshake stalls the input only when both registers are full
// reset (rst, synchronous): slots cleared and inactive, scheduler awake
module periodic_task_release_timer_core #(
  parameter int TASK_SLOTS = ptrt_pkg::TASK_SLOTS_DEF,
  parameter int COUNT_BITS = ptrt_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  ptrt_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output ptrt_pkg::result_t result
);

  ptrt_pkg::item_t       item_q;
  logic                  item_q_valid;
  logic                  awake;
  logic                  awake_next;
  logic                  advance;
  logic                  do_tick;
  logic                  do_load;
  logic                  do_suspend;
  logic [COUNT_BITS-1:0] period;
  logic [COUNT_BITS-1:0] delay;
  logic [TASK_SLOTS-1:0] due_vec;

  assign advance    = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_ready) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  always_comb begin
    do_tick    = 1'b0;
    do_load    = 1'b0;
    do_suspend = 1'b0;
    awake_next = awake;
    unique case (item_q.cmd)
      ptrt_pkg::CMD_TICK:    do_tick    = advance && awake;
      ptrt_pkg::CMD_LOAD:    do_load    = advance;
      ptrt_pkg::CMD_SUSPEND: do_suspend = advance;
      ptrt_pkg::CMD_SLEEP:   awake_next = 1'b0;
      default:               awake_next = awake;
    endcase
  end

  // load values keep their low bits or widen with zeros
  if (COUNT_BITS <= ptrt_pkg::TICK_BITS) begin : g_narrow
    assign period = item_q.period_ticks[COUNT_BITS-1:0];
    assign delay  = item_q.delay_ticks[COUNT_BITS-1:0];
  end else begin : g_wide
    assign period = {{(COUNT_BITS-ptrt_pkg::TICK_BITS){1'b0}}, item_q.period_ticks};
    assign delay  = {{(COUNT_BITS-ptrt_pkg::TICK_BITS){1'b0}}, item_q.delay_ticks};
  end

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_slot
    ptrt_pkg::slot_ctl_t ctl;
    logic                hit;

    assign hit         = (item_q.task_index == ptrt_pkg::IDX_BITS'(i));
    assign ctl.tick    = do_tick;
    assign ctl.load    = do_load && hit;
    assign ctl.suspend = do_suspend && hit;

    ptrt_slot #(
      .COUNT_BITS(COUNT_BITS)
    ) u_slot (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .period (period),
      .delay  (delay),
      .due    (due_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awake        <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        awake        <= awake_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.due_mask <= ptrt_pkg::MAX_SLOTS'(due_vec);
      result.running  <= awake_next;
    end
  end

`ifndef SYNTHESIS
  a_sleep_sticks: assert property (@(posedge clk) disable iff (rst)
    !awake |=> !awake)
    else $error("scheduler woke without reset");

  a_asleep_no_due: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.running |-> result.due_mask == '0)
    else $error("release reported while asleep");

  a_mask_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.due_mask >> TASK_SLOTS) == '0)
    else $error("release bit beyond configured slots");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid && result.running == awake)
    else $error("result register not loaded on advance");
`endif

endmodule
